### rtl/core/region_bitmap_id_allocator_macros.svh
// Assertion macros for the region bitmap ID allocator.
`ifndef REGION_BITMAP_ID_ALLOCATOR_MACROS_SVH
`define REGION_BITMAP_ID_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define RBA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RBA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/rba_pkg.sv
package rba_pkg;

   localparam int FIRST_CAPACITY = 64;
   localparam int REGION_LIMIT   = 4;
   localparam int VALUE_WIDTH    = 32;
   localparam int ID_W           = 14;
   localparam int CMD_W          = 2;
   localparam int STATUS_W       = 2;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 4;
   localparam int ZS_W           = 3;
   localparam int NODE_W         = 4;
   localparam int WORD_BITS      = 64;
   localparam int POS_W          = $clog2(WORD_BITS);
   localparam int ID_STORE       = FIRST_CAPACITY * ((1 << REGION_LIMIT) - 1);
   localparam int BM_WORDS       = (ID_STORE + WORD_BITS - 1) / WORD_BITS;
   localparam int G_W            = $clog2(ID_STORE);
   localparam int WORD_W         = $clog2(BM_WORDS);
   localparam int CNT_W          = $clog2(FIRST_CAPACITY << (REGION_LIMIT - 1)) + 1;
   localparam int RL_W           = $clog2(REGION_LIMIT);
   localparam int RC_W           = $clog2(REGION_LIMIT + 1);

   localparam logic [CMD_W-1:0] CMD_ALLOC    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RELEASE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOOKUP   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_VALUE_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_SHIFT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_ID     = 2'd2;

   typedef struct packed {
      logic latch_req;
      logic region_clr;
      logic region_inc;
      logic word_load_nf;
      logic word_load_ff;
      logic word_inc;
      logic set_cursor_cap;
      logic clear_avail;
      logic take_nf;
      logic take_ff;
      logic create;
      logic rd_issue;
      logic rd_finish;
      logic fail_nf;
      logic fail_full;
   } ctrl_cmd_type;

   typedef struct packed {
      logic region_valid;
      logic region_avail;
      logic region_exhausted;
      logic region_full;
      logic cursor_lt_cap;
      logic hit;
      logic last_word;
      logic can_create;
      logic lookup_ok;
   } dp_status_type;

   function automatic logic [G_W-1:0] base_of(input logic [RC_W-1:0] k);
      int t;
      t = FIRST_CAPACITY * ((1 << k) - 1);
      return G_W'(t);
   endfunction

   function automatic logic [CNT_W-1:0] cap_of(input logic [RL_W-1:0] k);
      int t;
      t = FIRST_CAPACITY << k;
      return CNT_W'(t);
   endfunction

   function automatic logic [WORD_W-1:0] last_word_of(input logic [RL_W-1:0] k);
      int t;
      t = (FIRST_CAPACITY * ((2 << k) - 1)) / WORD_BITS - 1;
      return WORD_W'(t);
   endfunction

   function automatic logic [ID_W-1:0] encode(input logic [G_W-1:0] g,
                                             input logic [ZS_W-1:0] zs,
                                             input logic [NODE_W-1:0] node);
      logic [G_W+7:0] s;
      logic [7:0]     zm;
      s  = {8'd0, g} << zs;
      zm = 8'((9'd1 << zs) - 9'd1);
      return ID_W'(s | {{(G_W){1'b0}}, zm & {4'd0, node}});
   endfunction

endpackage

### rtl/core/region_bitmap_id_allocator.sv
// Region bitmap ID allocator, one zone.
// Commands enter on req_cmd/req_id/req_value: a beat is taken on a clock
// edge with req_start high and busy low. Allocate (0) gives an ID next-fit
// inside regions of doubling size, reusing freed IDs first-fit from zero once
// a region's cursor reaches its end; release (1) frees an ID and returns its
// value; lookup (2) returns the value with status ok when the ID exists.
// Each result beat shows on rsp_* for one cycle with rsp_valid high; the
// receiver cannot stall, and the next command can be taken in that cycle.
// Release and lookup pass through a decode state and a read state before the
// result, and answer from the decode state when the ID is unknown, the node
// bits differ or the command is unused. Allocate visits regions in order
// (creating a region or answering pool full counts as a visit) and scans the
// 64-bit bitmap words of a region, a single word read per cycle; a region may
// be scanned twice, from its cursor and then from zero.
// csr_we writes the value mode (0), the index shift (1) or node_id (2) from csr_wdata; the
// user must write only while busy is low and no result is pending: the block does not enforce it.
// Reset clears the bitmap and region state directly; there is no clearing pass.
`include "region_bitmap_id_allocator_macros.svh"

module region_bitmap_id_allocator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_start,
   output logic                                busy,
   input  logic [rba_pkg::CMD_W-1:0]           req_cmd,
   input  logic [rba_pkg::ID_W-1:0]            req_id,
   input  logic [rba_pkg::VALUE_WIDTH-1:0]     req_value,
   output logic                                rsp_valid,
   output logic [rba_pkg::STATUS_W-1:0]        rsp_status,
   output logic [rba_pkg::ID_W-1:0]            rsp_new_id,
   output logic [rba_pkg::VALUE_WIDTH-1:0]     rsp_bound_value,
   input  logic                                csr_we,
   input  logic [rba_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rba_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import rba_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          rsp_fail;
   logic          rsp_data_zero;

   rba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_start (req_start),
      .req_cmd   (req_cmd),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   rba_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_cmd         (req_cmd),
      .req_id          (req_id),
      .req_value       (req_value),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_status      (rsp_status),
      .rsp_new_id      (rsp_new_id),
      .rsp_bound_value (rsp_bound_value)
   );

   assign rsp_fail      = rsp_valid && (rsp_status != ST_OK);
   assign rsp_data_zero = (rsp_new_id == '0) && (rsp_bound_value == '0);

   `RBA_ASSERT_NXT(a_accept_busy, clock, reset, req_start && !busy, busy, "accepted beat did not raise busy")
   `RBA_ASSERT_NXT(a_single_beat, clock, reset, rsp_valid, !rsp_valid, "result beat repeated")
   `RBA_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, !busy, "result beat while still busy")
   `RBA_ASSERT_IMP(a_fail_zero, clock, reset, rsp_fail, rsp_data_zero, "failed beat carries data")

endmodule

### rtl/core/rba_ctrl.sv
module rba_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_start,
   input  logic [rba_pkg::CMD_W-1:0]    req_cmd,
   input  rba_pkg::dp_status_type       status,
   output rba_pkg::ctrl_cmd_type        cmd,
   output logic                         busy,
   output logic                         rsp_valid
);
   import rba_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_REGION  = 6'b000010,
      S_SCAN_NF = 6'b000100,
      S_SCAN_FF = 6'b001000,
      S_DECODE  = 6'b010000,
      S_READ    = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_start) begin
               cmd.latch_req  = 1'b1;
               cmd.region_clr = 1'b1;
               state_in = (req_cmd == CMD_ALLOC) ? S_REGION : S_DECODE;
            end
         end
         S_REGION: begin
            if (!status.region_valid) begin
               if (status.can_create) cmd.create = 1'b1;
               else cmd.fail_full = 1'b1;
               state_in = S_IDLE;
            end else if (!status.region_avail) begin
               cmd.region_inc = 1'b1;
            end else if (status.region_exhausted) begin
               cmd.clear_avail = 1'b1;
               cmd.region_inc  = 1'b1;
            end else if (status.cursor_lt_cap) begin
               cmd.word_load_nf = 1'b1;
               state_in = S_SCAN_NF;
            end else begin
               cmd.word_load_ff = 1'b1;
               state_in = S_SCAN_FF;
            end
         end
         S_SCAN_NF: begin
            if (status.hit) begin
               cmd.take_nf = 1'b1;
               state_in = S_IDLE;
            end else if (status.last_word) begin
               cmd.set_cursor_cap = 1'b1;
               cmd.word_load_ff   = 1'b1;
               state_in = S_SCAN_FF;
            end else begin
               cmd.word_inc = 1'b1;
            end
         end
         S_SCAN_FF: begin
            if (status.hit) begin
               cmd.take_ff = 1'b1;
               state_in = S_IDLE;
            end else if (status.last_word) begin
               cmd.clear_avail = status.region_full;
               cmd.region_inc  = 1'b1;
               state_in = S_REGION;
            end else begin
               cmd.word_inc = 1'b1;
            end
         end
         S_DECODE: begin
            if (status.lookup_ok) begin
               cmd.rd_issue = 1'b1;
               state_in = S_READ;
            end else begin
               cmd.fail_nf = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            cmd.rd_finish = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = cmd.take_nf | cmd.take_ff | cmd.create | cmd.rd_finish |
                     cmd.fail_nf | cmd.fail_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/core/rba_datapath.sv
module rba_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  rba_pkg::ctrl_cmd_type               cmd,
   output rba_pkg::dp_status_type              status,
   input  logic [rba_pkg::CMD_W-1:0]           req_cmd,
   input  logic [rba_pkg::ID_W-1:0]            req_id,
   input  logic [rba_pkg::VALUE_WIDTH-1:0]     req_value,
   input  logic                                csr_we,
   input  logic [rba_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rba_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic [rba_pkg::STATUS_W-1:0]        rsp_status,
   output logic [rba_pkg::ID_W-1:0]            rsp_new_id,
   output logic [rba_pkg::VALUE_WIDTH-1:0]     rsp_bound_value
);
   import rba_pkg::*;

   logic                   value_mode_ff;
   logic [ZS_W-1:0]        index_shift_ff;
   logic [NODE_W-1:0]      node_id_ff;

   logic [CMD_W-1:0]       cmd_ff;
   logic [ID_W-1:0]        id_ff;
   logic [VALUE_WIDTH-1:0] value_ff;

   logic [WORD_BITS-1:0]   bitmap_ff [BM_WORDS];
   logic [VALUE_WIDTH-1:0] value_mem [ID_STORE];
   logic [VALUE_WIDTH-1:0] rd_data_ff;

   logic [RC_W-1:0]        created_ff;
   logic [CNT_W-1:0]       cursor_ff [REGION_LIMIT];
   logic [CNT_W-1:0]       used_ff   [REGION_LIMIT];
   logic [REGION_LIMIT-1:0] full_ff;
   logic [REGION_LIMIT-1:0] avail_ff;

   logic [RC_W-1:0]        region_ff;
   logic [WORD_W-1:0]      word_ff;
   logic                   phase_nf_ff;

   logic [STATUS_W-1:0]    status_ff;
   logic [ID_W-1:0]        new_id_ff;
   logic [VALUE_WIDTH-1:0] bound_ff;

   logic [RL_W-1:0]        ri;
   logic [CNT_W-1:0]       cap;
   logic [G_W-1:0]         base;
   logic [WORD_W-1:0]      cursor_word;
   logic [WORD_BITS-1:0]   mask;
   logic [WORD_BITS-1:0]   free_bits;
   logic [POS_W-1:0]       pos;
   logic [G_W-1:0]         take_g;
   logic [CNT_W-1:0]       take_off;
   logic [CNT_W-1:0]       cursor_next;
   logic [G_W-1:0]         create_g;
   logic                   take;
   logic [7:0]             zm;
   logic                   node_ok;
   logic [ID_W-1:0]        idx;
   logic                   in_created;
   logic                   bit_set;
   logic [RL_W-1:0]        rel_r;
   logic                   is_release;

   assign ri          = region_ff[RL_W-1:0];
   assign cap         = cap_of(ri);
   assign base        = base_of(region_ff);
   assign cursor_word = WORD_W'(base >> POS_W) + WORD_W'(cursor_ff[ri] >> POS_W);

   always_comb begin
      mask = '1;
      if (phase_nf_ff && (word_ff == cursor_word)) begin
         mask = '1 << cursor_ff[ri][POS_W-1:0];
      end
      free_bits = ~bitmap_ff[word_ff] & mask;
      pos = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (free_bits[b]) pos = POS_W'(b);
      end
   end

   assign take_g      = {word_ff, pos};
   assign take_off    = CNT_W'(take_g - base);
   assign cursor_next = take_off + CNT_W'(1);
   assign create_g    = base_of(created_ff);
   assign take        = cmd.take_nf | cmd.take_ff;

   assign zm         = 8'((9'd1 << index_shift_ff) - 9'd1);
   assign node_ok    = ((id_ff[7:0] & zm) == ({4'd0, node_id_ff} & zm));
   assign idx        = id_ff >> index_shift_ff;
   assign in_created = (idx < ID_W'(base_of(created_ff)));
   assign bit_set    = in_created && bitmap_ff[idx[G_W-1:POS_W]][idx[POS_W-1:0]];
   assign is_release = (cmd_ff == CMD_RELEASE);

   always_comb begin
      rel_r = '0;
      for (int k = 1; k < REGION_LIMIT; k++) begin
         if (idx[G_W-1:0] >= base_of(RC_W'(k))) rel_r = RL_W'(k);
      end
   end

   always_comb begin
      status.region_valid     = (region_ff < created_ff);
      status.region_avail     = avail_ff[ri];
      status.region_full      = full_ff[ri];
      status.region_exhausted = full_ff[ri] && (used_ff[ri] >= cap);
      status.cursor_lt_cap    = (cursor_ff[ri] < cap);
      status.hit              = |free_bits;
      status.last_word        = (word_ff == last_word_of(ri));
      status.can_create       = (created_ff < RC_W'(REGION_LIMIT));
      status.lookup_ok        = ((cmd_ff == CMD_RELEASE) || (cmd_ff == CMD_LOOKUP)) &&
                                node_ok && bit_set;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_mode_ff  <= 1'b0;
         index_shift_ff <= '0;
         node_id_ff     <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VALUE_MODE:  value_mode_ff  <= csr_wdata[0];
            CSR_INDEX_SHIFT: index_shift_ff <= csr_wdata[ZS_W-1:0];
            CSR_NODE_ID:     node_id_ff     <= csr_wdata[NODE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         cmd_ff   <= req_cmd;
         id_ff    <= req_id;
         value_ff <= req_value;
      end
      if (cmd.word_load_nf) word_ff <= cursor_word;
      else if (cmd.word_load_ff) word_ff <= WORD_W'(base >> POS_W);
      else if (cmd.word_inc) word_ff <= word_ff + WORD_W'(1);
      if (cmd.word_load_nf) phase_nf_ff <= 1'b1;
      else if (cmd.word_load_ff) phase_nf_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (take) begin
         value_mem[take_g] <= value_mode_ff ? value_ff : '0;
      end else if (cmd.create) begin
         value_mem[create_g] <= value_mode_ff ? value_ff : '0;
      end
      if (cmd.rd_issue) rd_data_ff <= value_mem[idx[G_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < BM_WORDS; w++) bitmap_ff[w] <= '0;
         for (int k = 0; k < REGION_LIMIT; k++) begin
            cursor_ff[k] <= '0;
            used_ff[k]   <= '0;
         end
         full_ff    <= '0;
         avail_ff   <= REGION_LIMIT'(1);
         created_ff <= RC_W'(1);
         region_ff  <= '0;
      end else begin
         if (cmd.region_clr) region_ff <= '0;
         else if (cmd.region_inc) region_ff <= region_ff + RC_W'(1);
         if (cmd.clear_avail) avail_ff[ri] <= 1'b0;
         if (cmd.set_cursor_cap) cursor_ff[ri] <= cap;
         if (take) begin
            bitmap_ff[word_ff][pos] <= 1'b1;
            used_ff[ri] <= used_ff[ri] + CNT_W'(1);
         end
         if (cmd.take_nf) begin
            cursor_ff[ri] <= cursor_next;
            if (cursor_next >= cap) full_ff[ri] <= 1'b1;
         end
         if (cmd.take_ff) full_ff[ri] <= 1'b0;
         if (cmd.create) begin
            bitmap_ff[create_g[G_W-1:POS_W]][create_g[POS_W-1:0]] <= 1'b1;
            cursor_ff[created_ff[RL_W-1:0]] <= CNT_W'(1);
            used_ff[created_ff[RL_W-1:0]]   <= CNT_W'(1);
            full_ff[created_ff[RL_W-1:0]]   <= 1'b0;
            avail_ff[created_ff[RL_W-1:0]]  <= 1'b1;
            created_ff <= created_ff + RC_W'(1);
         end
         if (cmd.rd_finish && is_release) begin
            bitmap_ff[idx[G_W-1:POS_W]][idx[POS_W-1:0]] <= 1'b0;
            if (used_ff[rel_r] != '0) used_ff[rel_r] <= used_ff[rel_r] - CNT_W'(1);
            if (full_ff[rel_r]) begin
               full_ff[rel_r]  <= 1'b0;
               avail_ff[rel_r] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         status_ff <= ST_OK;
         new_id_ff <= encode(take_g, index_shift_ff, node_id_ff);
         bound_ff  <= '0;
      end else if (cmd.create) begin
         status_ff <= ST_OK;
         new_id_ff <= encode(create_g, index_shift_ff, node_id_ff);
         bound_ff  <= '0;
      end else if (cmd.rd_finish) begin
         status_ff <= ST_OK;
         new_id_ff <= '0;
         bound_ff  <= value_mode_ff ? rd_data_ff : '0;
      end else if (cmd.fail_nf || cmd.fail_full) begin
         status_ff <= cmd.fail_full ? ST_FULL : ST_NOT_FOUND;
         new_id_ff <= '0;
         bound_ff  <= '0;
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_new_id      = new_id_ff;
   assign rsp_bound_value = bound_ff;

endmodule

### tb/region_bitmap_id_allocator_scoreboard.sv
module region_bitmap_id_allocator_scoreboard
   import rba_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_start,
   input  logic                        busy,
   input  logic [CMD_W-1:0]            req_cmd,
   input  logic [ID_W-1:0]             req_id,
   input  logic [VALUE_WIDTH-1:0]      req_value,
   input  logic                        rsp_valid,
   input  logic [STATUS_W-1:0]         rsp_status,
   input  logic [ID_W-1:0]             rsp_new_id,
   input  logic [VALUE_WIDTH-1:0]      rsp_bound_value,
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata,
   output int                          fail_count,
   output int                          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [ID_W-1:0]        new_id;
      logic [VALUE_WIDTH-1:0] bound_value;
   } result_type;

   result_type result_q[$];

   bit                     cfg_value_mode;
   logic [ZS_W-1:0]        cfg_shift;
   logic [NODE_W-1:0]      cfg_node;

   bit                     id_taken[ID_STORE];
   logic [VALUE_WIDTH-1:0] id_value[ID_STORE];
   int                     regions_made;
   int                     reg_cursor[REGION_LIMIT];
   int                     reg_used[REGION_LIMIT];
   bit                     reg_full[REGION_LIMIT];
   bit                     reg_avail[REGION_LIMIT];

   function automatic int reg_cap(int k);
      return FIRST_CAPACITY << k;
   endfunction

   function automatic int reg_base(int k);
      return FIRST_CAPACITY * ((1 << k) - 1);
   endfunction

   function automatic logic [ID_W-1:0] pack_id(int idx);
      int zm;
      zm = (1 << cfg_shift) - 1;
      return ID_W'((idx << cfg_shift) | (cfg_node & zm));
   endfunction

   function automatic void grab(int r, int g, logic [VALUE_WIDTH-1:0] v);
      id_taken[g] = 1'b1;
      id_value[g] = cfg_value_mode ? v : '0;
      reg_used[r]++;
   endfunction

   function automatic int search_region(int r, logic [VALUE_WIDTH-1:0] v);
      int cap;
      int base;
      cap  = reg_cap(r);
      base = reg_base(r);
      if (reg_cursor[r] < cap) begin
         for (int b = reg_cursor[r]; b < cap; b++) begin
            if (!id_taken[base + b]) begin
               grab(r, base + b, v);
               reg_cursor[r] = b + 1;
               if (reg_cursor[r] >= cap) reg_full[r] = 1'b1;
               return b;
            end
         end
         reg_cursor[r] = cap;
      end
      for (int b = 0; b < cap; b++) begin
         if (!id_taken[base + b]) begin
            grab(r, base + b, v);
            reg_full[r] = 1'b0;
            return b;
         end
      end
      return cap;
   endfunction

   function automatic result_type predict(logic [CMD_W-1:0] c, logic [ID_W-1:0] id,
                                          logic [VALUE_WIDTH-1:0] v);
      result_type res;
      int         zm;
      int         off;
      int         r;
      int         idx;
      res = '{ST_NOT_FOUND, '0, '0};
      if (c == CMD_ALLOC) begin
         for (int i = 0; i < regions_made; i++) begin
            if (!reg_avail[i]) continue;
            if (reg_full[i] && reg_used[i] >= reg_cap(i)) begin
               reg_avail[i] = 1'b0;
               continue;
            end
            off = search_region(i, v);
            if (off < reg_cap(i)) begin
               res.status = ST_OK;
               res.new_id = pack_id(reg_base(i) + off);
               return res;
            end
            if (reg_full[i]) reg_avail[i] = 1'b0;
         end
         if (regions_made < REGION_LIMIT) begin
            r = regions_made;
            regions_made++;
            reg_cursor[r] = 0;
            reg_used[r]   = 0;
            reg_full[r]   = 1'b0;
            reg_avail[r]  = 1'b1;
            off = search_region(r, v);
            if (off < reg_cap(r)) begin
               res.status = ST_OK;
               res.new_id = pack_id(reg_base(r) + off);
               return res;
            end
         end
         res.status = ST_FULL;
         return res;
      end
      if (c != CMD_RELEASE && c != CMD_LOOKUP) return res;
      zm = (1 << cfg_shift) - 1;
      if ((id & zm) != (cfg_node & zm)) return res;
      idx = id >> cfg_shift;
      r = REGION_LIMIT;
      for (int i = 0; i < regions_made; i++)
         if (idx >= reg_base(i) && idx < reg_base(i) + reg_cap(i)) r = i;
      if (r == REGION_LIMIT || idx >= ID_STORE) return res;
      if (!id_taken[idx]) return res;
      res.status      = ST_OK;
      res.bound_value = cfg_value_mode ? id_value[idx] : '0;
      if (c == CMD_RELEASE) begin
         id_value[idx] = '0;
         id_taken[idx] = 1'b0;
         if (reg_used[r] > 0) reg_used[r]--;
         if (reg_full[r]) begin
            reg_full[r]  = 1'b0;
            reg_avail[r] = 1'b1;
         end
      end
      return res;
   endfunction

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         cfg_value_mode = 1'b0;
         cfg_shift      = '0;
         cfg_node       = '0;
         for (int g = 0; g < ID_STORE; g++) begin
            id_taken[g] = 1'b0;
            id_value[g] = '0;
         end
         for (int k = 0; k < REGION_LIMIT; k++) begin
            reg_cursor[k] = 0;
            reg_used[k]   = 0;
            reg_full[k]   = 1'b0;
            reg_avail[k]  = (k == 0);
         end
         regions_made = 1;
         result_q.delete();
      end else begin
         if (rsp_valid) begin
            if (result_q.size() == 0) begin
               $display("%0t: unexpected result beat status=%0d new_id=%0h value=%0h",
                        $realtime, rsp_status, rsp_new_id, rsp_bound_value);
               fail_count++;
            end else begin
               want = result_q.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $realtime, want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_new_id !== want.new_id) begin
                  $display("%0t: new_id expected %0h actual %0h",
                           $realtime, want.new_id, rsp_new_id);
                  fail_count++;
               end
               if (rsp_bound_value !== want.bound_value) begin
                  $display("%0t: bound_value expected %0h actual %0h",
                           $realtime, want.bound_value, rsp_bound_value);
                  fail_count++;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_VALUE_MODE:  cfg_value_mode = csr_wdata[0];
               CSR_INDEX_SHIFT: cfg_shift = csr_wdata[ZS_W-1:0];
               CSR_NODE_ID:     cfg_node = csr_wdata;
               default: ;
            endcase
         end
         if (req_start && !busy) result_q.push_back(predict(req_cmd, req_id, req_value));
      end
      pending = result_q.size();
   end

endmodule

### tb/region_bitmap_id_allocator_test.sv
module region_bitmap_id_allocator_test;
   import rba_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_start;
   logic                   busy;
   logic [CMD_W-1:0]       req_cmd;
   logic [ID_W-1:0]        req_id;
   logic [VALUE_WIDTH-1:0] req_value;
   logic                   rsp_valid;
   logic [STATUS_W-1:0]    rsp_status;
   logic [ID_W-1:0]        rsp_new_id;
   logic [VALUE_WIDTH-1:0] rsp_bound_value;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     fail_count;
   int                     pending;
   int                     stuck_cycles = 0;
   int                     shift_now;
   int                     node_now;
   int                     live_ids = 0;

   always #5 clock = ~clock;

   region_bitmap_id_allocator uut (.*);

   region_bitmap_id_allocator_scoreboard scoreboard (.*);

   always @(posedge clock) begin
      if ((req_start && !busy) || rsp_valid || reset) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= 5000) begin
         $display("region_bitmap_id_allocator regression: fail");
         $finish;
      end
   end

   task automatic issue(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] id,
                        input logic [VALUE_WIDTH-1:0] v);
      req_start = 1'b1;
      req_cmd   = c;
      req_id    = id;
      req_value = v;
      do @(posedge clock); while (busy);
      @(negedge clock);
      if (c == CMD_ALLOC) live_ids++;
      else if (c == CMD_RELEASE && live_ids > 0) live_ids--;
   endtask

   task automatic pause(input int n);
      req_start = 1'b0;
      req_cmd   = 2'($urandom);
      req_id    = ID_W'($urandom);
      req_value = $urandom;
      repeat (n) @(negedge clock);
   endtask

   task automatic drain;
      req_start = 1'b0;
      while (pending != 0 || busy) @(negedge clock);
      repeat (45) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int data);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = CSR_DATA_W'(data);
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_INDEX_SHIFT) shift_now = data;
      if (idx == CSR_NODE_ID) node_now = data;
   endtask

   function automatic logic [ID_W-1:0] make_id(int idx);
      return ID_W'((idx << shift_now) | (node_now & ((1 << shift_now) - 1)));
   endfunction

   task automatic random_beats(input int count, input int alloc_pct, input bit quiet);
      int r;
      int top;
      logic [ID_W-1:0] id;
      for (int n = 0; n < count; n++) begin
         r   = $urandom_range(99);
         top = live_ids + live_ids / 4 + 4;
         if (top > ID_STORE - 1) top = ID_STORE - 1;
         id = ($urandom_range(99) < 85) ? make_id($urandom_range(top)) : ID_W'($urandom);
         if (r < alloc_pct) issue(CMD_ALLOC, ID_W'($urandom), $urandom);
         else if (r < alloc_pct + (100 - alloc_pct) * 4 / 10) issue(CMD_RELEASE, id, $urandom);
         else if (r < alloc_pct + (100 - alloc_pct) * 8 / 10) issue(CMD_LOOKUP, id, $urandom);
         else if (r < alloc_pct + (100 - alloc_pct) * 9 / 10) issue(CMD_RESERVED, id, $urandom);
         else issue(2'($urandom), ID_W'($urandom), $urandom);
         if (!quiet && $urandom_range(99) < 20) pause($urandom_range(1, 12));
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_start = 1'b0;
      req_cmd   = CMD_ALLOC;
      req_id    = '0;
      req_value = '0;
      csr_we    = 1'b0;
      csr_index = CSR_VALUE_MODE;
      csr_wdata = '0;
      shift_now = 0;
      node_now  = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_reg(CSR_VALUE_MODE, 1);
      write_reg(CSR_INDEX_SHIFT, 0);
      write_reg(CSR_NODE_ID, 0);
      issue(CMD_ALLOC, '0, 32'h0000_0000);
      issue(CMD_ALLOC, '1, 32'hFFFF_FFFF);
      issue(CMD_ALLOC, '0, 32'hA5A5_5A5A);
      issue(CMD_LOOKUP, make_id(1), '0);
      issue(CMD_RELEASE, make_id(0), '1);
      issue(CMD_LOOKUP, make_id(0), '0);
      issue(CMD_RELEASE, make_id(0), '0);
      issue(CMD_LOOKUP, 14'h3FFF, '0);
      issue(CMD_RELEASE, 14'h3FFF, '0);
      issue(CMD_RESERVED, make_id(1), '1);
      issue(CMD_LOOKUP, make_id(900), '0);
      issue(CMD_ALLOC, '0, 32'h1234_5678);
      drain();
      write_reg(CSR_INDEX_SHIFT, 4);
      write_reg(CSR_NODE_ID, 15);
      issue(CMD_ALLOC, '0, 32'hFFFF_FFFF);
      issue(CMD_LOOKUP, make_id(1), '0);
      issue(CMD_LOOKUP, make_id(1) ^ 14'h1, '0);
      issue(CMD_RELEASE, make_id(2) ^ 14'h8, '0);
      issue(CMD_RELEASE, make_id(1), '0);
      drain();

      write_reg(CSR_VALUE_MODE, 0);
      write_reg(CSR_INDEX_SHIFT, 2);
      write_reg(CSR_NODE_ID, 3);
      random_beats(180, 60, 1'b0);
      drain();
      write_reg(CSR_VALUE_MODE, 1);
      write_reg(CSR_INDEX_SHIFT, 0);
      write_reg(CSR_NODE_ID, 9);
      random_beats(380, 95, 1'b0);
      drain();
      write_reg(CSR_INDEX_SHIFT, 1);
      write_reg(CSR_NODE_ID, 1);
      random_beats(200, 45, 1'b0);
      drain();
      write_reg(CSR_VALUE_MODE, 0);
      write_reg(CSR_INDEX_SHIFT, 3);
      write_reg(CSR_NODE_ID, 0);
      random_beats(200, 75, 1'b0);
      drain();
      write_reg(CSR_VALUE_MODE, 1);
      write_reg(CSR_INDEX_SHIFT, 4);
      write_reg(CSR_NODE_ID, 6);
      random_beats(120, 70, 1'b1);
      drain();

      if (fail_count == 0) $display("region_bitmap_id_allocator regression: pass");
      else $display("region_bitmap_id_allocator regression: fail");
      $finish;
   end

endmodule
